// File: sv/multiturn_encoder_feedback_decoder_defines.svh
// Assertion macros for the multi-turn encoder feedback decoder.
`ifndef MULTITURN_ENCODER_FEEDBACK_DECODER_DEFINES_SVH
`define MULTITURN_ENCODER_FEEDBACK_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a condition at every clock edge outside reset.
`define MTEFD_ASSERT(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("mtefd: assertion failed");
// Check that a condition leads to a consequence in the next cycle.
`define MTEFD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mtefd: assertion failed");
`else
`define MTEFD_ASSERT(label, expr)
`define MTEFD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: sv/mtefd_pkg.sv
// Constants and types shared by the multi-turn encoder feedback decoder.
package mtefd_pkg;

   // Encoder resolution and derived widths
   localparam int COUNTS_PER_TURN = 8192;
   localparam int HALF_TURN       = COUNTS_PER_TURN / 2;
   localparam int CPT_W           = $clog2(COUNTS_PER_TURN + 1);
   localparam int PROD_W          = 16 + CPT_W + 1;
   localparam int TOT_W           = (PROD_W + 1 > 33) ? PROD_W + 1 : 33;

   // Calibration register reset value
   localparam logic [7:0] CAL_RESET = 8'd50;
   localparam logic [7:0] FRAME_MAX = 8'hFF;

   // Divide by five: multiply by a reciprocal and shift
   localparam logic [15:0] DIV5_MULT  = 16'd52429;
   localparam int          DIV5_SHIFT = 18;
   localparam int          CMD_W      = 14;

   // Stream widths
   localparam int REQ_W = 64;
   localparam int RSP_W = 112;

   // One captured request beat, with the command already scaled
   typedef struct packed {
      logic [15:0]             angle;
      logic signed [15:0]      speed;
      logic signed [CMD_W-1:0] command;
      logic [7:0]              temperature;
      logic [3:0]              length;
   } req_beat_type;

   // One result beat
   typedef struct packed {
      logic                    calibrating;
      logic [15:0]             rotor_angle;
      logic signed [15:0]      speed_value;
      logic signed [CMD_W-1:0] scaled_command;
      logic [7:0]              temperature;
      logic signed [15:0]      turn_count;
      logic signed [31:0]      unwrapped_angle;
      logic [3:0]              frame_length;
   } rsp_beat_type;

endpackage

// File: sv/mtefd_command_scale.sv
// Commanded current word divided by minus five, truncated toward zero.
module mtefd_command_scale
   import mtefd_pkg::*;
(
   input  logic signed [15:0]      word,
   output logic signed [CMD_W-1:0] scaled
);

   logic [15:0]         mag;
   logic [31:0]         prod;
   logic [CMD_W-1:0]    quot;

   // Take the magnitude, divide it by five, then apply the inverted sign
   always_comb begin
      mag    = word[15] ? (~word + 16'd1) : word;
      prod   = 32'(mag) * 32'(DIV5_MULT);
      quot   = prod[DIV5_SHIFT +: CMD_W];
      scaled = word[15] ? $signed(quot) : $signed(~quot + 14'd1);
   end

endmodule

// File: sv/multiturn_encoder_feedback_decoder.sv
// Multi-turn encoder feedback decoder: one feedback frame in, one result beat out.
// A request beat passes through the input register and then the result register.
// Throughput: one frame per cycle; a stalled result holds the input register, then req_tready.
// The turn unwrap and total-angle multiply sit between the two registers.
// Reset (synchronous, active high) clears all held state and sets the calibration index to 50.
`include "multiturn_encoder_feedback_decoder_defines.svh"

module multiturn_encoder_feedback_decoder
   import mtefd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // Request stream; tdata from bit 0: angle_high, angle_low, speed_high, speed_low,
   // command_high, command_low, temperature_byte, length_code, zero fill
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   // Response stream; tdata from bit 0: rotor_angle, speed_value, scaled_command,
   // temperature, turn_count, unwrapped_angle, frame_length, zero fill
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,
   // Response tuser: calibrating
   output logic             rsp_tuser,
   // Calibration last-frame register
   input  logic             csr_we,
   input  logic [7:0]       csr_wdata
);

   localparam logic signed [17:0]       HALF_S = 18'(HALF_TURN);
   localparam logic signed [CPT_W:0]    CPT_S  = (CPT_W + 1)'(COUNTS_PER_TURN);
   localparam logic signed [TOT_W-1:0]  SAT_HI = TOT_W'(64'sd2147483647);
   localparam logic signed [TOT_W-1:0]  SAT_LO = -TOT_W'(64'sd2147483648);

   // Control and held state
   logic                     in_valid_ff;
   logic                     rsp_valid_ff;
   logic [7:0]               cal_ff;
   logic [7:0]               frame_counter_ff, frame_counter_in;
   logic [15:0]              offset_ff, offset_in;
   logic [15:0]              held_angle_ff, held_angle_in;
   logic signed [15:0]       turns_ff, turns_in;
   logic signed [15:0]       held_speed_ff, held_speed_in;
   logic signed [CMD_W-1:0]  held_command_ff, held_command_in;
   logic [7:0]               held_temp_ff, held_temp_in;

   // Payload registers
   req_beat_type             in_ff, in_in;
   rsp_beat_type             rsp_ff, rsp_in;

   logic                     advance;
   logic                     req_accept;
   logic                     calib;
   logic signed [CMD_W-1:0]  command_scaled;
   logic signed [17:0]       diff;
   logic signed [PROD_W-1:0] prod;
   logic signed [16:0]       angle_delta;
   logic signed [TOT_W-1:0]  total_wide;
   logic signed [31:0]       total_sat;
   logic signed [15:0]       turn_step;

   // Handshake
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   // Scale the commanded current on its way into the input register
   mtefd_command_scale u_scale (
      .word   ($signed({req_tdata[39:32], req_tdata[47:40]})),
      .scaled (command_scaled)
   );

   // Unpack the request beat
   always_comb begin
      in_in.angle       = {req_tdata[7:0], req_tdata[15:8]};
      in_in.speed       = $signed({req_tdata[23:16], req_tdata[31:24]});
      in_in.command     = command_scaled;
      in_in.temperature = req_tdata[55:48];
      in_in.length      = req_tdata[59:56];
   end

   // Decode one frame against the held state
   always_comb begin
      calib            = frame_counter_ff <= cal_ff;
      frame_counter_in = (frame_counter_ff != FRAME_MAX) ? frame_counter_ff + 8'd1
                                                         : frame_counter_ff;
      diff             = $signed({2'b00, in_ff.angle}) - $signed({2'b00, held_angle_ff});
      offset_in        = offset_ff;
      held_angle_in    = held_angle_ff;
      held_speed_in    = held_speed_ff;
      held_command_in  = held_command_ff;
      held_temp_in     = held_temp_ff;
      turns_in         = turns_ff;
      if (calib) begin
         offset_in = in_ff.angle;
      end else begin
         held_angle_in   = in_ff.angle;
         held_speed_in   = in_ff.speed;
         held_command_in = in_ff.command;
         held_temp_in    = in_ff.temperature;
         if (diff > HALF_S) begin
            if (turns_ff != -16'sd32768) turns_in = turns_ff - 16'sd1;
         end else if (diff < -HALF_S) begin
            if (turns_ff != 16'sd32767) turns_in = turns_ff + 16'sd1;
         end
      end

      // Total angle from the state after the frame, saturated to 32 bits
      prod        = PROD_W'(turns_in) * PROD_W'(CPT_S);
      angle_delta = $signed({1'b0, held_angle_in}) - $signed({1'b0, offset_in});
      total_wide  = TOT_W'(prod) + TOT_W'(angle_delta);
      if (total_wide > SAT_HI)      total_sat = 32'sh7FFFFFFF;
      else if (total_wide < SAT_LO) total_sat = 32'sh80000000;
      else                          total_sat = total_wide[31:0];

      rsp_in.calibrating     = calib;
      rsp_in.rotor_angle     = held_angle_in;
      rsp_in.speed_value     = held_speed_in;
      rsp_in.scaled_command  = held_command_in;
      rsp_in.temperature     = held_temp_in;
      rsp_in.turn_count      = turns_in;
      rsp_in.unwrapped_angle = total_sat;
      rsp_in.frame_length    = in_ff.length;
   end

   // Hold control and decoder state; advance it on each processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         cal_ff           <= CAL_RESET;
         frame_counter_ff <= '0;
         offset_ff        <= '0;
         held_angle_ff    <= '0;
         turns_ff         <= '0;
         held_speed_ff    <= '0;
         held_command_ff  <= '0;
         held_temp_ff     <= '0;
      end else begin
         if (csr_we) cal_ff <= csr_wdata;
         if (req_accept)   in_valid_ff <= 1'b1;
         else if (advance) in_valid_ff <= 1'b0;
         if (advance)         rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         if (advance) begin
            frame_counter_ff <= frame_counter_in;
            offset_ff        <= offset_in;
            held_angle_ff    <= held_angle_in;
            turns_ff         <= turns_in;
            held_speed_ff    <= held_speed_in;
            held_command_ff  <= held_command_in;
            held_temp_ff     <= held_temp_in;
         end
      end
   end

   // Load payload registers
   always_ff @(posedge clock) begin
      if (req_accept) in_ff  <= in_in;
      if (advance)    rsp_ff <= rsp_in;
   end

   // Drive the response stream
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.calibrating;
   assign rsp_tdata  = {6'd0, rsp_ff.frame_length, rsp_ff.unwrapped_angle, rsp_ff.turn_count,
                        rsp_ff.temperature, rsp_ff.scaled_command, rsp_ff.speed_value,
                        rsp_ff.rotor_angle};

   // Turn count moves by at most one per frame
   assign turn_step = turns_in - turns_ff;

   // Assertions
   `MTEFD_ASSERT_NEXT(a_counter_sticks, frame_counter_ff == FRAME_MAX, frame_counter_ff == FRAME_MAX)
   `MTEFD_ASSERT_NEXT(a_calib_holds, advance && calib, $stable(held_angle_ff) && $stable(turns_ff))
   `MTEFD_ASSERT(a_turn_step, turn_step == 16'sd0 || turn_step == 16'sd1 || turn_step == -16'sd1)
   `MTEFD_ASSERT(a_stall_cause, req_tready || (in_valid_ff && rsp_valid_ff && !rsp_tready))

endmodule

// File: test/multiturn_encoder_feedback_decoder_tb.sv
// Testbench for the multi-turn encoder feedback decoder: directed table, random frames, spins.
`timescale 1ns / 1ps

module multiturn_encoder_feedback_decoder_tb
   import mtefd_pkg::*;
();

   // One feedback frame as words, before packing into request beats
   typedef struct packed {
      logic [15:0] angle;
      logic [15:0] speed;
      logic [15:0] command;
      logic [7:0]  temp;
      logic [3:0]  len;
   } frame_type;

   typedef enum logic [1:0] {ROW_FRAME, ROW_CSR} row_kind_type;

   // One row of the directed table: a frame, or a calibration register write
   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   csr_value;
      frame_type    frame;
      logic         typed;
      rsp_beat_type want;
   } stim_row_type;

   localparam int N_ROWS       = 21;
   localparam int HOLD_CYCLES  = 60;
   localparam int SETTLE       = 4;
   localparam int PHASE_ITEMS  = 200;
   localparam int N_PHASES     = 7;
   localparam int SPIN_TURNS   = 8;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;
   logic             csr_we;
   logic [7:0]       csr_wdata;

   // Decoder state as predicted from accepted frames
   logic [7:0]              cal_last;
   logic [7:0]              frame_count;
   logic [15:0]             zero_offset;
   logic [15:0]             held_angle;
   logic signed [15:0]      turn_q;
   logic signed [15:0]      held_speed;
   logic signed [CMD_W-1:0] held_command;
   logic [7:0]              held_temp;

   rsp_beat_type expected_beats[$];
   int           mismatch_count;
   int           beat_count;
   int           req_idle_pct;
   int           rsp_idle_pct;
   int           hold_asked;
   int           hold_given;
   int           hold_left;
   logic [15:0]  last_sent_angle;

   // Directed frames; the first rows calibrate under the reset register value
   stim_row_type directed_rows [N_ROWS] = '{
      '{ROW_FRAME, 8'd0, '{16'h0000, 16'h7FFF, 16'h8000, 8'hFF, 4'd8}, 1'b1,
        '{1'b1, 16'h0000, 16'sd0, 14'sd0, 8'h00, 16'sd0, 32'sd0, 4'd8}},
      '{ROW_FRAME, 8'd0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00, 4'd0}, 1'b1,
        '{1'b1, 16'h0000, 16'sd0, 14'sd0, 8'h00, 16'sd0, -32'sd65535, 4'd0}},
      '{ROW_FRAME, 8'd0, '{16'h1234, 16'h8000, 16'h7FFF, 8'h80, 4'd15}, 1'b1,
        '{1'b1, 16'h0000, 16'sd0, 14'sd0, 8'h00, 16'sd0, -32'sd4660, 4'd15}},
      '{ROW_FRAME, 8'd0, '{16'h0100, 16'h0001, 16'h0005, 8'h01, 4'd9}, 1'b1,
        '{1'b1, 16'h0000, 16'sd0, 14'sd0, 8'h00, 16'sd0, -32'sd256, 4'd9}},
      '{ROW_CSR, 8'd3, '0, 1'b0, '0},
      // first measured frame: held angle is zero, so a far angle counts a turn down
      '{ROW_FRAME, 8'd0, '{16'hFFFF, 16'h7FFF, 16'h8000, 8'hFF, 4'd8}, 1'b1,
        '{1'b0, 16'hFFFF, 16'sd32767, 14'sd6553, 8'hFF, -16'sd1, 32'sd57087, 4'd8}},
      '{ROW_FRAME, 8'd0, '{16'h0000, 16'h8000, 16'h7FFF, 8'h00, 4'd0}, 1'b1,
        '{1'b0, 16'h0000, 16'sh8000, -14'sd6553, 8'h00, 16'sd0, -32'sd256, 4'd0}},
      '{ROW_FRAME, 8'd0, '{16'h0000, 16'hFFFF, 16'hFFFF, 8'h80, 4'd15}, 1'b1,
        '{1'b0, 16'h0000, -16'sd1, 14'sd0, 8'h80, 16'sd0, -32'sd256, 4'd15}},
      // half-turn boundaries: exactly half does not count, one past does
      '{ROW_FRAME, 8'd0, '{16'h1000, 16'h0010, 16'h0004, 8'h10, 4'd1}, 1'b0, '0},
      '{ROW_FRAME, 8'd0, '{16'h0000, 16'hFFF0, 16'hFFFB, 8'h20, 4'd2}, 1'b0, '0},
      '{ROW_FRAME, 8'd0, '{16'h1001, 16'h0100, 16'h0005, 8'h30, 4'd3}, 1'b0, '0},
      '{ROW_FRAME, 8'd0, '{16'h0000, 16'hFF00, 16'hFFFA, 8'h40, 4'd4}, 1'b0, '0},
      '{ROW_FRAME, 8'd0, '{16'h1FFF, 16'h1234, 16'h0006, 8'h50, 4'd6}, 1'b0, '0},
      '{ROW_FRAME, 8'd0, '{16'h0000, 16'h4321, 16'hFFF6, 8'h60, 4'd7}, 1'b0, '0},
      // angle at and above one turn is used as is
      '{ROW_FRAME, 8'd0, '{16'h2000, 16'h0F0F, 16'h00FF, 8'h70, 4'd12}, 1'b0, '0},
      '{ROW_FRAME, 8'd0, '{16'hAAAA, 16'h5555, 16'hAAAA, 8'h55, 4'd10}, 1'b0, '0},
      '{ROW_FRAME, 8'd0, '{16'h5555, 16'hAAAA, 16'h5555, 8'hAA, 4'd5}, 1'b0, '0},
      // a register of 255 makes every frame calibrate
      '{ROW_CSR, 8'd255, '0, 1'b0, '0},
      '{ROW_FRAME, 8'd0, '{16'h0FFF, 16'h0002, 16'h0003, 8'h04, 4'd11}, 1'b0, '0},
      '{ROW_CSR, 8'd0, '0, 1'b0, '0},
      '{ROW_FRAME, 8'd0, '{16'h0FFF, 16'h0002, 16'h0003, 8'h04, 4'd14}, 1'b0, '0}
   };

   logic [7:0] phase_settings [N_PHASES] =
      '{8'd100, 8'd254, 8'd255, 8'd0, 8'd128, 8'd255, 8'd50};

   multiturn_encoder_feedback_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the predicted state by one frame and return the result it causes
   function automatic rsp_beat_type decode_frame(input frame_type f);
      rsp_beat_type r;
      logic         calib;
      int           diff;
      int           quotient;
      longint       sum;
      calib = (frame_count <= cal_last);
      if (frame_count != FRAME_MAX) frame_count = frame_count + 8'd1;
      if (calib) begin
         zero_offset = f.angle;
      end else begin
         diff = int'(f.angle) - int'(held_angle);
         held_angle = f.angle;
         held_speed = f.speed;
         quotient = int'($signed(f.command)) / -5;
         held_command = quotient[CMD_W-1:0];
         held_temp = f.temp;
         if (diff > HALF_TURN) begin
            if (turn_q != 16'sh8000) turn_q = turn_q - 16'sd1;
         end else if (diff < -HALF_TURN) begin
            if (turn_q != 16'sh7FFF) turn_q = turn_q + 16'sd1;
         end
      end
      sum = longint'(turn_q) * COUNTS_PER_TURN + longint'(held_angle)
            - longint'(zero_offset);
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      r.calibrating     = calib;
      r.rotor_angle     = held_angle;
      r.speed_value     = held_speed;
      r.scaled_command  = held_command;
      r.temperature     = held_temp;
      r.turn_count      = turn_q;
      r.unwrapped_angle = sum[31:0];
      r.frame_length    = f.len;
      return r;
   endfunction

   task automatic report(input string field, input logic [31:0] got,
                         input logic [31:0] want);
      mismatch_count++;
      $display("mismatch at beat %0d, %s: got %h, expected %h", beat_count, field, got, want);
   endtask

   // Offer one frame after a random gap; hold it until accepted
   task automatic send_frame(input frame_type f, input logic typed, input rsp_beat_type want);
      rsp_beat_type predicted;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'h0, f.len, f.temp, f.command[7:0], f.command[15:8],
                     f.speed[7:0], f.speed[15:8], f.angle[7:0], f.angle[15:8]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = decode_frame(f);
      expected_beats.push_back(typed ? want : predicted);
      last_sent_angle = f.angle;
   endtask

   // Stop offering and wait until every expected beat has come out
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_calibration(input logic [7:0] value);
      drain_results();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      cal_last = value;
   endtask

   // Random frame: mostly plausible rotation, with jumps, edge deltas and noise
   function automatic frame_type random_frame();
      frame_type f;
      int        pick;
      pick = $urandom_range(99);
      if (pick < 45)
         f.angle = (last_sent_angle + 16'($urandom_range(6000)) - 16'd3000) & 16'h1FFF;
      else if (pick < 70)
         f.angle = 16'($urandom_range(COUNTS_PER_TURN - 1));
      else if (pick < 85)
         f.angle = last_sent_angle + (($urandom_range(1)) ? 16'd4096 : 16'd4097) *
                   (($urandom_range(1)) ? 16'd1 : 16'hFFFF);
      else
         f.angle = 16'($urandom);
      f.speed   = 16'($urandom);
      f.command = 16'($urandom);
      if ($urandom_range(9) == 0) begin
         case ($urandom_range(3))
            0: f.command = 16'h8000;
            1: f.command = 16'h7FFF;
            2: f.command = 16'hFFFB;
            default: f.command = 16'h0005;
         endcase
         f.speed = ($urandom_range(1)) ? 16'h8000 : 16'h7FFF;
      end
      f.temp = 8'($urandom);
      f.len  = ($urandom_range(99) < 80) ? 4'($urandom_range(8)) : 4'($urandom_range(15));
      return f;
   endfunction

   // Result side: random stalls, plus an occasional long hold-off
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_asked != hold_given) begin
         rsp_tready <= 1'b0;
         hold_given <= hold_asked;
         hold_left  <= HOLD_CYCLES;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Compare each result beat with the oldest expectation
   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_beats.size() == 0) begin
            report("unexpected beat", rsp_tdata[31:0], 32'h0);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_tuser !== want.calibrating)
               report("calibrating", 32'(rsp_tuser), 32'(want.calibrating));
            if (rsp_tdata[15:0] !== want.rotor_angle)
               report("rotor_angle", 32'(rsp_tdata[15:0]), 32'(want.rotor_angle));
            if (rsp_tdata[31:16] !== want.speed_value)
               report("speed_value", 32'(rsp_tdata[31:16]), 32'(want.speed_value));
            if (rsp_tdata[45:32] !== want.scaled_command)
               report("scaled_command", 32'(rsp_tdata[45:32]), 32'(want.scaled_command));
            if (rsp_tdata[53:46] !== want.temperature)
               report("temperature", 32'(rsp_tdata[53:46]), 32'(want.temperature));
            if (rsp_tdata[69:54] !== want.turn_count)
               report("turn_count", 32'(rsp_tdata[69:54]), 32'(want.turn_count));
            if (rsp_tdata[101:70] !== want.unwrapped_angle)
               report("unwrapped_angle", rsp_tdata[101:70], want.unwrapped_angle);
            if (rsp_tdata[105:102] !== want.frame_length)
               report("frame_length", 32'(rsp_tdata[105:102]), 32'(want.frame_length));
         end
         beat_count++;
      end
   end

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      int        guard;
      logic      rising;
      frame_type f;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_wdata  <= '0;
      rsp_tready <= 1'b0;
      hold_asked = 0;
      hold_given = 0;
      hold_left  = 0;
      mismatch_count = 0;
      beat_count     = 0;
      req_idle_pct   = 35;
      rsp_idle_pct   = 35;
      last_sent_angle = '0;
      cal_last     = CAL_RESET;
      frame_count  = '0;
      zero_offset  = '0;
      held_angle   = '0;
      turn_q       = '0;
      held_speed   = '0;
      held_command = '0;
      held_temp    = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      for (int i = 0; i < N_ROWS; i++) begin
         if (directed_rows[i].kind == ROW_CSR)
            write_calibration(directed_rows[i].csr_value);
         else
            send_frame(directed_rows[i].frame, directed_rows[i].typed, directed_rows[i].want);
      end

      // Random phases, each under its own calibration setting
      for (int p = 0; p < N_PHASES; p++) begin
         write_calibration((p == 4) ? 8'($urandom_range(1, 253)) : phase_settings[p]);
         req_idle_pct = (p == 3) ? 0 : 35;
         rsp_idle_pct = (p == 3) ? 0 : 35;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 1 && i == 60) hold_asked++;
            if (p == 2 && i == 100) drain_results();
            f = random_frame();
            send_frame(f, 1'b0, '0);
         end
      end

      // Spin a few whole turns each way at full rate
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      for (int dir = 0; dir < 2; dir++) begin
         rising = (dir == 0);
         for (int t = 0; t < SPIN_TURNS; t++) begin
            for (int k = 0; k < 3; k++) begin
               f = random_frame();
               f.angle = rising ? 16'(k * 4000) : 16'((2 - k) * 4000);
               send_frame(f, 1'b0, '0);
            end
         end
      end

      // Let the last beats out, then settle
      req_tvalid <= 1'b0;
      guard = 0;
      while (expected_beats.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_beats.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
